// ===== rtl/core/xre_pkg.sv =====
// ----------------------------------------------------------------------------
// xre_pkg
// Shared constants, types and the generator step for the xorshift event block.
// ----------------------------------------------------------------------------
package xre_pkg;

    localparam int unsigned STATE_W = 64;
    localparam int unsigned DIV_W   = 32;
    localparam int unsigned CNT_W   = $clog2(STATE_W + 1);

    localparam logic [STATE_W-1:0] STATE_RESET = 64'h135b_78d8_e29a_4d5c;

    localparam int unsigned SHIFT_A = 13;
    localparam int unsigned SHIFT_B = 7;
    localparam int unsigned SHIFT_C = 17;

    // Item kinds.
    localparam logic KIND_EVENT  = 1'b0;
    localparam logic KIND_RESEED = 1'b1;

    // Status handed from the remainder unit to the sequencer.
    typedef struct packed {
        logic done;
        logic rem_zero;
    } rem_status_t;

    // One xorshift step.
    function automatic logic [STATE_W-1:0] advance(input logic [STATE_W-1:0] w);
        logic [STATE_W-1:0] a;
        logic [STATE_W-1:0] b;
        a = w ^ (w << SHIFT_A);
        b = a ^ (a >> SHIFT_B);
        return b ^ (b << SHIFT_C);
    endfunction

endpackage

// ===== rtl/core/xre_rem.sv =====
// ----------------------------------------------------------------------------
// xre_rem
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module xre_rem
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [xre_pkg::STATE_W-1:0]      dividend,
    input  logic [xre_pkg::DIV_W-1:0]        divisor,
    output xre_pkg::rem_status_t             status
);

    logic [xre_pkg::CNT_W-1:0]   cnt_reg;
    logic [xre_pkg::CNT_W-1:0]   cnt_next;
    logic                        done_reg;
    logic                        done_next;
    logic [xre_pkg::STATE_W-1:0] dvd_reg;
    logic [xre_pkg::STATE_W-1:0] dvd_next;
    logic [xre_pkg::DIV_W-1:0]   rem_reg;
    logic [xre_pkg::DIV_W-1:0]   rem_next;
    logic [xre_pkg::DIV_W-1:0]   dsr_reg;
    logic [xre_pkg::DIV_W-1:0]   dsr_next;
    logic [xre_pkg::DIV_W:0]     trial;
    logic [xre_pkg::DIV_W:0]     diff;

    // The partial remainder stays below the divisor, so the trial value is
    // below twice the divisor and one subtract restores it.
    assign trial = {rem_reg, dvd_reg[xre_pkg::STATE_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = done_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            cnt_next  = xre_pkg::CNT_W'(xre_pkg::STATE_W);
            done_next = 1'b0;
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            dvd_next = {dvd_reg[xre_pkg::STATE_W-2:0], 1'b0};
            if (!diff[xre_pkg::DIV_W])
            begin
                rem_next = diff[xre_pkg::DIV_W-1:0];
            end
            else
            begin
                rem_next = trial[xre_pkg::DIV_W-1:0];
            end
            if (cnt_reg == xre_pkg::CNT_W'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);

endmodule

// ===== rtl/core/xorshift_random_event.sv =====
// A reseed word or an event word with a zero divisor gives its result in the
// cycle after it is accepted. An event word with a nonzero divisor steps the
// generator in the accepting cycle, then goes through the bit-serial remainder
// unit (one dividend bit per cycle); the result register loads its answer once
// the unit is done and the register is free. Words are taken one at a time.
// Reset is asynchronous and loads the generator constant.
// ----------------------------------------------------------------------------
// xorshift_random_event
// 64-bit xorshift generator that reports a one-in-N event per draw.
// ----------------------------------------------------------------------------
module xorshift_random_event
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             kind,
    input  logic [xre_pkg::DIV_W-1:0]        one_in,
    input  logic [xre_pkg::STATE_W-1:0]      seed_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             event_res,
    output logic [xre_pkg::STATE_W-1:0]      random_word,
    output logic                             divide_error
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DIV  = 2'b10
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [xre_pkg::STATE_W-1:0] gen_reg;
    logic [xre_pkg::STATE_W-1:0] gen_next;
    logic                        ovalid_reg;
    logic                        ovalid_next;
    logic                        event_reg;
    logic                        event_next;
    logic                        err_reg;
    logic                        err_next;
    logic [xre_pkg::STATE_W-1:0] stepped;
    logic                        out_free;
    logic                        in_fire;
    logic                        rem_start;
    xre_pkg::rem_status_t        rem_status;

    assign stepped  = xre_pkg::advance(gen_reg);
    assign out_free = !ovalid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign in_fire  = in_valid && in_ready;

    xre_rem u_rem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (stepped),
        .divisor  (one_in),
        .status   (rem_status)
    );

    always_comb
    begin
        state_next  = state_reg;
        gen_next    = gen_reg;
        ovalid_next = ovalid_reg;
        event_next  = event_reg;
        err_next    = err_reg;
        rem_start   = 1'b0;
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (kind == xre_pkg::KIND_RESEED)
                    begin
                        gen_next    = gen_reg ^ seed_value;
                        ovalid_next = 1'b1;
                        event_next  = 1'b0;
                        err_next    = 1'b0;
                    end
                    else if (one_in == '0)
                    begin
                        gen_next    = stepped;
                        ovalid_next = 1'b1;
                        event_next  = 1'b0;
                        err_next    = 1'b1;
                    end
                    else
                    begin
                        gen_next   = stepped;
                        rem_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                // The remainder unit holds its answer until the result
                // register can take it.
                if (rem_status.done && out_free)
                begin
                    ovalid_next = 1'b1;
                    event_next  = rem_status.rem_zero;
                    err_next    = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            gen_reg    <= xre_pkg::STATE_RESET;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            gen_reg    <= gen_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        event_reg <= event_next;
        err_reg   <= err_next;
    end

    assign out_valid    = ovalid_reg;
    assign event_res    = event_reg;
    assign divide_error = err_reg;
    assign random_word  = gen_reg;

endmodule

// ===== rtl/core/xre_checker.sv =====
// ----------------------------------------------------------------------------
// xre_checker
// Port-level checks for the xorshift event block, bound to the top level.
// ----------------------------------------------------------------------------
module xre_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             kind,
    input logic [xre_pkg::DIV_W-1:0]        one_in,
    input logic [xre_pkg::STATE_W-1:0]      seed_value,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic                             event_res,
    input logic [xre_pkg::STATE_W-1:0]      random_word,
    input logic                             divide_error
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(random_word)
            && $stable(event_res) && $stable(divide_error))
        else $error("result word changed while stalled");

    a_err_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_error |-> !event_res)
        else $error("event reported together with a divide error");

    // A reseed answers in the next cycle with no event and no error.
    a_reseed: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind == xre_pkg::KIND_RESEED
            |=> out_valid && !event_res && !divide_error
                && random_word == ($past(seed_value) ^ $past(random_word)))
        else $error("reseed result wrong");

    // A draw with a nonzero divisor goes through the remainder unit.
    a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind == xre_pkg::KIND_EVENT && one_in != '0
            |=> !out_valid && !in_ready)
        else $error("draw result appeared without the remainder pass");

endmodule

bind xorshift_random_event xre_checker u_xre_checker (.*);
